### sv/rtli_pkg.sv
// ----------------------------------------------------------------------------
// rtli_pkg
// Shared types and codes for the radix tree lookup/insert unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rtli_pkg;

  localparam int KEY_FIELD_W = 32;
  localparam int VALUE_BITS  = 32;
  localparam int SHIFT_W     = 8;   // covers (levels-1) * digit_bits up to 62 * 4

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic REG_DIGIT_BITS = 1'b0;
  localparam logic REG_LEVELS     = 1'b1;

  typedef struct packed {
    logic                   mode;
    logic [KEY_FIELD_W-1:0] key;
    logic [VALUE_BITS-1:0]  new_value;
  } cmd_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] read_value;
    logic                  status;
  } rsp_t;

  // effective (normalized) tree shape
  typedef struct packed {
    logic [2:0] digit_bits;
    logic [5:0] levels;
  } shape_t;

endpackage

`default_nettype wire

### sv/radix_tree_lookup_insert_unit.sv
// ----------------------------------------------------------------------------
// radix_tree_lookup_insert_unit
// Fixed-height radix tree (multi-level table) holding key/value words.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a cmd word (mode, key, new_value) is taken on a clock
//   edge where start is high and busy is low. mode GET walks the tree and
//   returns the leaf value (zero if a link is missing); mode SET builds the
//   path, allocating nodes from a pool of NODE_POOL, and writes the value.
//   Result channel: done pulses for one cycle with rsp (read_value, status).
//   The receiver cannot stall: rsp is valid only in the done cycle.
//   Status FULL means the pool ran out; nodes already linked stay in place.
//   Config port: wr_en/wr_index/wr_data write digit_bits (0) or levels (1);
//   any write empties the tree. Write only while busy is low.
// Timing:
//   All tree nodes live in one single-port RAM with a registered read, so
//   each level takes a read state, S_READ, then a check state, S_CHECK.
//   A GET on an empty tree finishes straight from idle; a SET at the last
//   level writes the value in the read state and finishes. Each newly
//   allocated node (root included) has its 2^digit_bits entries zeroed in
//   S_CLEAR before the walk goes on.
//   One command is in flight at a time; busy drops in the done cycle.
// Reset: pool empty, digit_bits = 4, levels = 8; RAM needs no clearing since
//   nodes are zeroed as they are allocated.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_tree_lookup_insert_unit
  import rtli_pkg::*;
#(
  parameter int MAX_DIGIT_BITS = 4,
  parameter int NODE_POOL      = 256,
  parameter int KEY_WIDTH      = 32,
  parameter int VALUE_WIDTH    = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire cmd_t       cmd,
  output logic            done,
  output rsp_t            rsp,
  input  wire logic       wr_en,
  input  wire logic       wr_index,
  input  wire logic [5:0] wr_data
);

  localparam int NODE_W  = $clog2(NODE_POOL);
  localparam int ADDR_W  = NODE_W + MAX_DIGIT_BITS;
  localparam int DEPTH   = NODE_POOL * (2 ** MAX_DIGIT_BITS);
  localparam int VW      = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;
  // entries hold either a leaf value or a child number plus one
  localparam int ENTRY_W = (VW > NODE_W + 1) ? VW : NODE_W + 1;

  // config registers, raw as written
  logic [2:0] digit_bits;
  logic [5:0] levels;
  shape_t     shape;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_bits <= 3'd4;
      levels     <= 6'd8;
    end else if (wr_en) begin
      case (wr_index)
        REG_DIGIT_BITS: digit_bits <= wr_data[2:0];
        REG_LEVELS:     levels     <= wr_data;
        default: ;
      endcase
    end
  end

  // digit width clamped to 1..MAX_DIGIT_BITS, height at least one
  always_comb begin
    shape.digit_bits = digit_bits;
    if (digit_bits == 3'd0) begin
      shape.digit_bits = 3'd1;
    end else if (int'(digit_bits) > MAX_DIGIT_BITS) begin
      shape.digit_bits = 3'(MAX_DIGIT_BITS);
    end
    shape.levels = (levels == 6'd0) ? 6'd1 : levels;
  end

  rtli_walk #(
    .MAX_DIGIT_BITS (MAX_DIGIT_BITS),
    .NODE_POOL      (NODE_POOL),
    .KEY_WIDTH      (KEY_WIDTH),
    .VALUE_WIDTH    (VALUE_WIDTH),
    .ENTRY_W        (ENTRY_W),
    .ADDR_W         (ADDR_W)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .shape      (shape),
    .tree_clear (wr_en),
    .busy       (busy),
    .done       (done),
    .rsp        (rsp),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  rtli_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

### sv/rtli_ram.sv
// ----------------------------------------------------------------------------
// rtli_ram
// Generic single-port RAM, synchronous write, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rtli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### sv/rtli_walk.sv
// ----------------------------------------------------------------------------
// rtli_walk
// Tree walk sequencer: one memory access per step, node allocation and
// node clearing, node pool count.
// ----------------------------------------------------------------------------
`default_nettype none

module rtli_walk
  import rtli_pkg::*;
#(
  parameter int MAX_DIGIT_BITS = 4,
  parameter int NODE_POOL      = 256,
  parameter int KEY_WIDTH      = 32,
  parameter int VALUE_WIDTH    = 32,
  parameter int ENTRY_W        = 32,
  parameter int ADDR_W         = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire cmd_t               cmd,
  input  wire shape_t             shape,
  input  wire logic               tree_clear,
  output logic                    busy,
  output logic                    done,
  output rsp_t                    rsp,
  output logic                    mem_we,
  output logic [ADDR_W-1:0]       mem_addr,
  output logic [ENTRY_W-1:0]      mem_wdata,
  input  wire logic [ENTRY_W-1:0] mem_rdata
);

  localparam int NODE_W = ADDR_W - MAX_DIGIT_BITS;
  localparam int CNT_W  = NODE_W + 1;
  localparam int KW     = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
  localparam int VW     = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;
  localparam logic [KEY_FIELD_W-1:0] KEY_MASK = {KEY_FIELD_W{1'b1}} >> (KEY_FIELD_W - KW);
  localparam logic [VALUE_BITS-1:0]  VAL_MASK = {VALUE_BITS{1'b1}} >> (VALUE_BITS - VW);
  localparam logic [CNT_W-1:0]       POOL_FULL = CNT_W'(NODE_POOL);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_CHECK
  } state_t;

  state_t                    state;
  logic                      mode;
  logic [KEY_FIELD_W-1:0]    key;
  logic [VALUE_BITS-1:0]     value;
  logic [5:0]                lvl;
  logic [SHIFT_W-1:0]        shift;
  logic [NODE_W-1:0]         node;
  logic [MAX_DIGIT_BITS-1:0] clr_cnt;
  logic [CNT_W-1:0]          nodes_used;

  logic [KEY_FIELD_W-1:0]    key_sh;
  logic [MAX_DIGIT_BITS-1:0] dmask;
  logic [MAX_DIGIT_BITS-1:0] digit;
  logic [ENTRY_W-1:0]        link_m1;
  logic                      link_ok;
  logic                      last_lvl;
  logic [5:0]                lvm1;
  logic [SHIFT_W-1:0]        shift_init;

  assign dmask      = {MAX_DIGIT_BITS{1'b1}} >> (MAX_DIGIT_BITS - int'(shape.digit_bits));
  assign key_sh     = key >> shift;
  assign digit      = key_sh[MAX_DIGIT_BITS-1:0] & dmask;
  assign link_m1    = mem_rdata - ENTRY_W'(1);
  assign link_ok    = (mem_rdata != '0) && (mem_rdata <= ENTRY_W'(nodes_used));
  assign last_lvl   = (lvl == 6'd1);
  assign lvm1       = shape.levels - 6'd1;
  assign shift_init = SHIFT_W'(SHIFT_W'(lvm1) * SHIFT_W'(shape.digit_bits));
  assign busy       = (state != S_IDLE);

  // memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {node, digit};
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = {node, clr_cnt};
      end
      S_READ: begin
        if (mode == MODE_SET && last_lvl) begin
          mem_we    = 1'b1;
          mem_wdata = ENTRY_W'(value);
        end
      end
      S_CHECK: begin
        // allocate a fresh node and link it in place of the missing child
        if (mode == MODE_SET && !last_lvl && !link_ok && nodes_used != POOL_FULL) begin
          mem_we    = 1'b1;
          mem_wdata = ENTRY_W'(nodes_used) + ENTRY_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      nodes_used <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (tree_clear) begin
            nodes_used <= '0;
          end
          if (start) begin
            mode    <= cmd.mode;
            key     <= cmd.key & KEY_MASK;
            value   <= cmd.new_value & VAL_MASK;
            lvl     <= shape.levels;
            shift   <= shift_init;
            node    <= '0;
            clr_cnt <= '0;
            if (cmd.mode == MODE_SET) begin
              if (nodes_used == '0) begin
                nodes_used <= CNT_W'(1);
                state      <= S_CLEAR;
              end else begin
                state <= S_READ;
              end
            end else if (nodes_used == '0) begin
              done           <= 1'b1;
              rsp.read_value <= '0;
              rsp.status     <= STATUS_OK;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == dmask) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (mode == MODE_SET && last_lvl) begin
            done           <= 1'b1;
            rsp.read_value <= '0;
            rsp.status     <= STATUS_OK;
            state          <= S_IDLE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (mode == MODE_GET) begin
            if (last_lvl) begin
              done           <= 1'b1;
              rsp.read_value <= VALUE_BITS'(mem_rdata);
              rsp.status     <= STATUS_OK;
              state          <= S_IDLE;
            end else if (link_ok) begin
              node  <= link_m1[NODE_W-1:0];
              lvl   <= lvl - 6'd1;
              shift <= shift - SHIFT_W'(shape.digit_bits);
              state <= S_READ;
            end else begin
              done           <= 1'b1;
              rsp.read_value <= '0;
              rsp.status     <= STATUS_OK;
              state          <= S_IDLE;
            end
          end else begin
            if (link_ok) begin
              node  <= link_m1[NODE_W-1:0];
              lvl   <= lvl - 6'd1;
              shift <= shift - SHIFT_W'(shape.digit_bits);
              state <= S_READ;
            end else if (nodes_used == POOL_FULL) begin
              done           <= 1'b1;
              rsp.read_value <= '0;
              rsp.status     <= STATUS_FULL;
              state          <= S_IDLE;
            end else begin
              nodes_used <= nodes_used + CNT_W'(1);
              node       <= nodes_used[NODE_W-1:0];
              lvl        <= lvl - 6'd1;
              shift      <= shift - SHIFT_W'(shape.digit_bits);
              clr_cnt    <= '0;
              state      <= S_CLEAR;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
